>>> hdl/blr_pkg.sv
// Shared types, codes and sizes of the branch link resolver.
package blr_pkg;

  localparam int MAX_PROGRAM = 4096;
  localparam int NEST_DEPTH  = 16;
  localparam int LOOP_DEPTH  = 16;

  localparam int TGT_W     = 12;
  localparam int VAL_W     = 13;
  localparam int NPTR_W    = $clog2(NEST_DEPTH + 1);
  localparam int NIDX_W    = $clog2(NEST_DEPTH);
  localparam int LPTR_W    = $clog2(LOOP_DEPTH + 1);
  localparam int LIDX_W    = $clog2(LOOP_DEPTH);
  localparam int MAX_RES   = 3;

  localparam logic [3:0] EK_PLAIN  = 4'd0;
  localparam logic [3:0] EK_IF     = 4'd1;
  localparam logic [3:0] EK_THEN   = 4'd2;
  localparam logic [3:0] EK_ELSE   = 4'd3;
  localparam logic [3:0] EK_END    = 4'd4;
  localparam logic [3:0] EK_START  = 4'd5;
  localparam logic [3:0] EK_FOR    = 4'd6;
  localparam logic [3:0] EK_NEXT   = 4'd7;
  localparam logic [3:0] EK_STEP   = 4'd8;
  localparam logic [3:0] EK_ARROW  = 4'd9;
  localparam logic [3:0] EK_DO     = 4'd10;
  localparam logic [3:0] EK_UNTIL  = 4'd11;
  localparam logic [3:0] EK_WHILE  = 4'd12;
  localparam logic [3:0] EK_REPEAT = 4'd13;

  localparam logic [1:0] NK_IF    = 2'd1;
  localparam logic [1:0] NK_DO    = 2'd2;
  localparam logic [1:0] NK_WHILE = 2'd3;

  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;
  localparam logic [1:0] SLOT_3 = 2'd3;

  localparam logic [4:0] ST_OK                = 5'd0;
  localparam logic [4:0] ST_THEN_NO_END       = 5'd1;
  localparam logic [4:0] ST_THEN_NO_IF        = 5'd2;
  localparam logic [4:0] ST_THEN_DUP          = 5'd3;
  localparam logic [4:0] ST_ELSE_NO_END       = 5'd4;
  localparam logic [4:0] ST_ELSE_NO_IF        = 5'd5;
  localparam logic [4:0] ST_ELSE_NO_THEN      = 5'd6;
  localparam logic [4:0] ST_ELSE_DUP          = 5'd7;
  localparam logic [4:0] ST_NEXT_NO_LOOP      = 5'd8;
  localparam logic [4:0] ST_STEP_NO_LOOP      = 5'd9;
  localparam logic [4:0] ST_MISSING_END       = 5'd10;
  localparam logic [4:0] ST_MISSING_DO        = 5'd11;
  localparam logic [4:0] ST_UNTIL_DUP         = 5'd12;
  localparam logic [4:0] ST_MISSING_WHILE     = 5'd13;
  localparam logic [4:0] ST_REPEAT_DUP        = 5'd14;
  localparam logic [4:0] ST_END_NO_BRANCH     = 5'd15;
  localparam logic [4:0] ST_MISSING_UNTIL     = 5'd17;
  localparam logic [4:0] ST_MISSING_REPEAT    = 5'd18;
  localparam logic [4:0] ST_MISSING_THEN      = 5'd19;
  localparam logic [4:0] ST_MISSING_NEXT      = 5'd20;
  localparam logic [4:0] ST_OVERFLOW          = 5'd21;

  typedef struct packed {
    logic [3:0] element_kind;
    logic       is_last_element;
  } item_t;

  typedef struct packed {
    logic             has_link;
    logic [TGT_W-1:0] target_index;
    logic [1:0]       arg_slot;
    logic [VAL_W-1:0] link_value;
    logic [4:0]       status;
    logic             done_res;
  } result_t;

  typedef struct packed {
    logic [1:0]              count;
    result_t [MAX_RES-1:0]   entry;
  } res_bundle_t;

  typedef struct packed {
    logic [TGT_W-1:0] opener;
    logic [TGT_W-1:0] mid;
    logic [TGT_W-1:0] alt;
    logic [1:0]       kind;
    logic             has_mid;
    logic             has_alt;
  } nest_entry_t;

endpackage

>>> hdl/blr_resolver.sv
// Program state, nesting and loop stacks, and the per-element link resolution.
module blr_resolver (
  input  logic                 clk,
  input  logic                 rst,
  input  blr_pkg::item_t       item,
  input  logic                 commit,
  output blr_pkg::res_bundle_t bundle
);
  import blr_pkg::*;

  logic [VAL_W-1:0]  position;
  logic [NPTR_W-1:0] nest_top;
  logic [LPTR_W-1:0] loop_top;
  logic              error_seen;
  nest_entry_t       nest_mem [NEST_DEPTH];
  logic [TGT_W-1:0]  loop_mem [LOOP_DEPTH];

  logic [NPTR_W-1:0] nest_top_m1;
  logic [LPTR_W-1:0] loop_top_m1;
  logic [NPTR_W-1:0] nest_top_after;
  logic [LPTR_W-1:0] loop_top_after;
  nest_entry_t       top_entry;
  logic              top_valid;
  logic [TGT_W-1:0]  lo;
  logic [TGT_W-1:0]  pos;
  logic [VAL_W-1:0]  pos_inc;
  logic [4:0]        code;
  logic [4:0]        fin;
  logic              push_n;
  logic              pop_n;
  logic              upd_mid;
  logic              upd_alt;
  logic              push_l;
  logic              pop_l;
  logic [1:0]        nl;
  result_t [MAX_RES-1:0] lk;

  function automatic result_t mk_link(logic [TGT_W-1:0] tgt, logic [1:0] slot,
                                      logic [VAL_W-1:0] val);
    result_t r;
    r = '0;
    r.has_link     = 1'b1;
    r.target_index = tgt;
    r.arg_slot     = slot;
    r.link_value   = val;
    return r;
  endfunction

  function automatic result_t mk_status(logic [4:0] st);
    result_t r;
    r = '0;
    r.status   = st;
    r.done_res = 1'b1;
    return r;
  endfunction

  assign nest_top_m1 = nest_top - NPTR_W'(1);
  assign loop_top_m1 = loop_top - LPTR_W'(1);
  assign top_valid   = (nest_top != '0);
  assign top_entry   = nest_mem[nest_top_m1[NIDX_W-1:0]];
  assign lo          = loop_mem[loop_top_m1[LIDX_W-1:0]];
  assign pos         = position[TGT_W-1:0];
  assign pos_inc     = position + VAL_W'(1);

  always_comb begin
    code    = ST_OK;
    push_n  = 1'b0;
    pop_n   = 1'b0;
    upd_mid = 1'b0;
    upd_alt = 1'b0;
    push_l  = 1'b0;
    pop_l   = 1'b0;
    nl      = 2'd0;
    lk      = '0;
    if (position >= VAL_W'(MAX_PROGRAM)) begin
      code = ST_OVERFLOW;
    end else begin
      case (item.element_kind)
        EK_IF, EK_DO, EK_WHILE: begin
          if (nest_top >= NPTR_W'(NEST_DEPTH)) code = ST_OVERFLOW;
          else push_n = 1'b1;
        end
        EK_THEN: begin
          if (item.is_last_element) code = ST_THEN_NO_END;
          else if (!top_valid) code = ST_THEN_NO_IF;
          else if (top_entry.has_mid) code = ST_THEN_DUP;
          else begin
            upd_mid = 1'b1;
            lk[0] = mk_link(pos, SLOT_1, pos_inc);
            lk[1] = mk_link(pos, SLOT_3, {1'b0, top_entry.opener});
            nl = 2'd2;
          end
        end
        EK_ELSE: begin
          if (item.is_last_element) code = ST_ELSE_NO_END;
          else if (!top_valid) code = ST_ELSE_NO_IF;
          else if (!top_entry.has_mid) code = ST_ELSE_NO_THEN;
          else if (top_entry.has_alt) code = ST_ELSE_DUP;
          else begin
            upd_alt = 1'b1;
            lk[0] = mk_link(pos, SLOT_1, pos_inc);
            lk[1] = mk_link(pos, SLOT_3, {1'b0, top_entry.opener});
            lk[2] = mk_link(top_entry.mid, SLOT_2, pos_inc);
            nl = 2'd3;
          end
        end
        EK_START, EK_FOR: begin
          if (loop_top >= LPTR_W'(LOOP_DEPTH)) code = ST_OVERFLOW;
          else begin
            push_l = 1'b1;
            if (item.element_kind == EK_FOR) begin
              lk[0] = mk_link(pos, SLOT_1, pos_inc);
              nl = 2'd1;
            end
          end
        end
        EK_NEXT, EK_STEP: begin
          if (loop_top == '0) begin
            code = (item.element_kind == EK_NEXT) ? ST_NEXT_NO_LOOP : ST_STEP_NO_LOOP;
          end else begin
            pop_l = 1'b1;
            lk[0] = mk_link(pos, SLOT_1, {1'b0, lo});
            lk[1] = mk_link(lo, SLOT_2, position);
            nl = 2'd2;
          end
        end
        EK_ARROW: begin
          lk[0] = mk_link(pos, SLOT_1, position);
          nl = 2'd1;
        end
        EK_UNTIL: begin
          if (item.is_last_element) code = ST_MISSING_END;
          else if (!top_valid || top_entry.kind != NK_DO) code = ST_MISSING_DO;
          else if (top_entry.has_mid) code = ST_UNTIL_DUP;
          else upd_mid = 1'b1;
        end
        EK_REPEAT: begin
          if (!top_valid || top_entry.kind != NK_WHILE) code = ST_MISSING_WHILE;
          else if (top_entry.has_mid) code = ST_REPEAT_DUP;
          else upd_mid = 1'b1;
        end
        EK_END: begin
          if (!top_valid) code = ST_END_NO_BRANCH;
          else if (top_entry.kind == NK_DO) begin
            if (!top_entry.has_mid) code = ST_MISSING_UNTIL;
            else begin
              lk[0] = mk_link(pos, SLOT_1, {1'b0, top_entry.opener} + VAL_W'(1));
              nl = 2'd1;
            end
          end else if (top_entry.kind == NK_WHILE) begin
            if (!top_entry.has_mid) code = ST_MISSING_REPEAT;
            else begin
              lk[0] = mk_link(pos, SLOT_2, {1'b0, top_entry.opener} + VAL_W'(1));
              lk[1] = mk_link(top_entry.mid, SLOT_1, pos_inc);
              nl = 2'd2;
            end
          end else begin
            if (top_entry.has_alt) begin
              lk[0] = mk_link(top_entry.alt, SLOT_2, position);
              nl = 2'd1;
            end else if (top_entry.has_mid) begin
              lk[0] = mk_link(top_entry.mid, SLOT_2, position);
              nl = 2'd1;
            end else begin
              code = ST_MISSING_THEN;
            end
          end
          pop_n = (code == ST_OK);
        end
        default: begin
        end
      endcase
    end
  end

  assign nest_top_after = nest_top + NPTR_W'(push_n) - NPTR_W'(pop_n);
  assign loop_top_after = loop_top + LPTR_W'(push_l) - LPTR_W'(pop_l);

  always_comb begin
    if (nest_top_after != '0) fin = ST_MISSING_END;
    else if (loop_top_after != '0) fin = ST_MISSING_NEXT;
    else fin = ST_OK;
  end

  always_comb begin
    bundle = '0;
    if (error_seen) begin
      bundle.count = 2'd0;
    end else if (code != ST_OK) begin
      bundle.entry[0] = mk_status(code);
      bundle.count    = 2'd1;
    end else begin
      bundle.entry = lk;
      bundle.count = nl;
      if (item.is_last_element && nl < 2'(MAX_RES)) begin
        bundle.entry[nl] = mk_status(fin);
        bundle.count     = nl + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      nest_top   <= '0;
      loop_top   <= '0;
      error_seen <= 1'b0;
    end else if (commit) begin
      if (item.is_last_element) begin
        position   <= '0;
        nest_top   <= '0;
        loop_top   <= '0;
        error_seen <= 1'b0;
      end else if (!error_seen) begin
        if (code != ST_OK) begin
          error_seen <= 1'b1;
        end else begin
          position <= pos_inc;
          nest_top <= nest_top_after;
          loop_top <= loop_top_after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && !error_seen && code == ST_OK) begin
      if (push_n) begin
        nest_mem[nest_top[NIDX_W-1:0]] <= '{
          opener:  pos,
          mid:     '0,
          alt:     '0,
          kind:    (item.element_kind == EK_IF) ? NK_IF :
                   (item.element_kind == EK_DO) ? NK_DO : NK_WHILE,
          has_mid: 1'b0,
          has_alt: 1'b0
        };
      end else if (upd_mid) begin
        nest_mem[nest_top_m1[NIDX_W-1:0]].mid     <= pos;
        nest_mem[nest_top_m1[NIDX_W-1:0]].has_mid <= 1'b1;
      end else if (upd_alt) begin
        nest_mem[nest_top_m1[NIDX_W-1:0]].alt     <= pos;
        nest_mem[nest_top_m1[NIDX_W-1:0]].has_alt <= 1'b1;
      end
      if (push_l) begin
        loop_mem[loop_top[LIDX_W-1:0]] <= pos;
      end
    end
  end

endmodule

>>> hdl/blr_result_queue.sv
// Result register that holds the results of one element and hands them out in order.
module blr_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  blr_pkg::res_bundle_t bundle,
  input  logic                 push,
  output logic                 free,
  output logic                 result_valid,
  input  logic                 result_stall,
  output blr_pkg::result_t     result
);
  import blr_pkg::*;

  result_t [MAX_RES-1:0] entries;
  logic [1:0]            remaining;
  logic [1:0]            head;
  logic                  take;

  assign result_valid = (remaining != 2'd0);
  assign result       = entries[head];
  assign take         = result_valid && !result_stall;
  assign free         = (remaining == 2'd0) || (remaining == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      head      <= 2'd0;
    end else if (push && free) begin
      remaining <= bundle.count;
      head      <= 2'd0;
    end else if (take) begin
      remaining <= remaining - 2'd1;
      head      <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      entries <= bundle.entry;
    end
  end

endmodule

>>> hdl/branch_link_resolver.sv
// Top level of the branch link resolver: input register, resolver and result queue.
//
//   channel   direction   payload    handshake
//   item      in          item_t     item_valid / item_stall
//   result    out         result_t   result_valid / result_stall
//
// An element is resolved combinationally from the input register and gives zero to
// three results, one per cycle on the result channel while result_stall is low; a new
// element's results are loaded as the single result port takes the last one before.
// Reset clears the position, the stack pointers, the error flag and both registers.
// A stalled result channel holds the queue; the input register still takes one element.
module branch_link_resolver (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  blr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output blr_pkg::result_t result
);
  import blr_pkg::*;

  logic        hold_valid;
  item_t       hold_item;
  res_bundle_t bundle;
  logic        q_free;
  logic        fire;
  logic        q_push;
  logic        accept;

  assign fire       = hold_valid && (q_free || bundle.count == 2'd0);
  assign q_push     = fire && bundle.count != 2'd0;
  assign item_stall = hold_valid && !fire;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= item;
    end
  end

  blr_resolver u_resolver (
    .clk    (clk),
    .rst    (rst),
    .item   (hold_item),
    .commit (fire),
    .bundle (bundle)
  );

  blr_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .bundle       (bundle),
    .push         (q_push),
    .free         (q_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_free)
    else $error("Result queue loaded while still holding results.");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !fire) |=> hold_valid)
    else $error("Input register dropped an element that was not resolved.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result valid after reset.");

  a_status_no_link: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.done_res) |-> (!result.has_link && result.status != ST_OK
      || !result.has_link))
    else $error("Final result carries a link write.");

endmodule
